[design/hsil_pkg.sv]
// Shared types and constants for the hash set insert/lookup block.
package hsil_pkg;

	localparam int unsigned KEY_W             = 32;
	localparam int unsigned RECIP_W           = 33;
	localparam int unsigned PROD_W            = KEY_W + RECIP_W;
	localparam int unsigned DEF_BUCKET_COUNT  = 101;
	localparam int unsigned DEF_WAYS          = 4;

	typedef enum logic {
		OP_INSERT = 1'b0,
		OP_LOOKUP = 1'b1
	} op_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_MAP1,
		ST_MAP2,
		ST_UPDATE
	} state_t;

endpackage

[design/hsil_bucket_map.sv]
// Two-stage key-to-bucket map: key modulo BUCKET_COUNT by reciprocal multiply.
module hsil_bucket_map #(
	parameter int unsigned BUCKET_COUNT = hsil_pkg::DEF_BUCKET_COUNT
) (
	input  logic                              clk,
	input  logic                              load,
	input  logic [hsil_pkg::KEY_W-1:0]        key,
	output logic [$clog2(BUCKET_COUNT)-1:0]   bucket
);
	import hsil_pkg::*;

	localparam int unsigned BW    = $clog2(BUCKET_COUNT);
	localparam int unsigned SHIFT = KEY_W + BW;
	// floor(2^SHIFT / D): the estimated quotient is exact or one short
	localparam logic [RECIP_W-1:0] RECIP =
		RECIP_W'((PROD_W'(1) << SHIFT) / PROD_W'(BUCKET_COUNT));

	logic [KEY_W-1:0]  key_s1;
	logic [PROD_W-1:0] prod_s1;
	logic [KEY_W-1:0]  key_s2;
	logic [KEY_W-1:0]  qd_s2;
	logic [KEY_W-1:0]  quot;
	logic [KEY_W-1:0]  rem;

	assign quot = KEY_W'(prod_s1 >> SHIFT);

	always_ff @(posedge clk) begin
		if (load) begin
			key_s1  <= key;
			prod_s1 <= PROD_W'(key) * PROD_W'(RECIP);
		end
		key_s2 <= key_s1;
		qd_s2  <= KEY_W'(quot * KEY_W'(BUCKET_COUNT));
	end

	always_comb begin
		rem = key_s2 - qd_s2;
		// fix up the one-short quotient
		if (rem >= KEY_W'(BUCKET_COUNT)) begin
			rem = rem - KEY_W'(BUCKET_COUNT);
		end
		bucket = BW'(rem);
	end

endmodule

[design/hash_set_insert_lookup.sv]
// Hash set top level: bucket map, bucket row memory, compare and write back.
// Each transaction carries an opcode (insert if absent, or look up) and a 32-bit
// key; the bucket is key modulo BUCKET_COUNT, and every bucket holds up to
// WAYS_PER_BUCKET keys plus a fill count in one memory row. A transaction goes
// through accept, two multiply stages of the bucket map, a row read, then
// compare and write back while the result is loaded into the output register
// (held while a stalled result waits); the input is taken again on the next
// cycle. After reset a clearing pass zeroes all fill counts, and in_stall stays
// high during it. An insert into a full bucket is dropped and reports bucket_full.
module hash_set_insert_lookup #(
	parameter int unsigned BUCKET_COUNT    = hsil_pkg::DEF_BUCKET_COUNT,
	parameter int unsigned WAYS_PER_BUCKET = hsil_pkg::DEF_WAYS
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic                        opcode,
	input  logic [hsil_pkg::KEY_W-1:0]  key,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic                        found,
	output logic                        inserted,
	output logic                        bucket_full
);
	import hsil_pkg::*;

	localparam int unsigned BW    = $clog2(BUCKET_COUNT);
	localparam int unsigned FW    = $clog2(WAYS_PER_BUCKET + 1);
	localparam int unsigned KEYS_W = WAYS_PER_BUCKET * KEY_W;
	localparam int unsigned ROW_W = KEYS_W + FW;

	state_t state_q, state_nxt;

	logic [KEY_W-1:0] key_q;
	logic             op_q;
	logic [BW-1:0]    bucket;
	logic [BW-1:0]    bucket_q;
	logic [BW-1:0]    clr_q;
	logic             clr_last;

	logic [ROW_W-1:0] mem [BUCKET_COUNT];
	logic [ROW_W-1:0] rd_q;
	logic             rd_en;
	logic             wr_en;
	logic [BW-1:0]    wr_addr;
	logic [ROW_W-1:0] wr_data;

	logic             load;
	logic             upd_go;
	logic [FW-1:0]    fill;
	logic             hit;
	logic             has_room;
	logic             do_ins;
	logic             do_full;
	logic [ROW_W-1:0] new_row;

	logic out_valid_q, found_q, inserted_q, full_q;

	hsil_bucket_map #(
		.BUCKET_COUNT(BUCKET_COUNT)
	) u_map (
		.clk    (clk),
		.load   (load),
		.key    (key),
		.bucket (bucket)
	);

	assign clr_last = (clr_q == BW'(BUCKET_COUNT - 1));
	assign upd_go   = !out_valid_q || !out_stall;

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_CLEAR:  if (clr_last) state_nxt = ST_IDLE;
			ST_IDLE:   if (in_valid) state_nxt = ST_MAP1;
			ST_MAP1:   state_nxt = ST_MAP2;
			ST_MAP2:   state_nxt = ST_UPDATE;
			ST_UPDATE: if (upd_go) state_nxt = ST_IDLE;
			default:   state_nxt = ST_CLEAR;
		endcase
	end

	always_comb begin
		in_stall = 1'b1;
		load     = 1'b0;
		rd_en    = 1'b0;
		wr_en    = 1'b0;
		wr_addr  = bucket_q;
		wr_data  = new_row;
		case (state_q)
			ST_CLEAR: begin
				wr_en   = 1'b1;
				wr_addr = clr_q;
				wr_data = '0;
			end
			ST_IDLE: begin
				in_stall = 1'b0;
				load     = in_valid;
			end
			ST_MAP2: begin
				rd_en = 1'b1;
			end
			ST_UPDATE: begin
				wr_en = upd_go && do_ins;
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

	// compare the stored ways below the fill count, build the updated row
	always_comb begin
		fill     = rd_q[ROW_W-1 -: FW];
		hit      = 1'b0;
		new_row  = rd_q;
		for (int w = 0; w < WAYS_PER_BUCKET; w++) begin
			if ((FW'(w) < fill) && (rd_q[w*KEY_W +: KEY_W] == key_q)) begin
				hit = 1'b1;
			end
			if (FW'(w) == fill) begin
				new_row[w*KEY_W +: KEY_W] = key_q;
			end
		end
		has_room = (fill < FW'(WAYS_PER_BUCKET));
		new_row[ROW_W-1 -: FW] = FW'(fill + FW'(1));
		do_ins  = !hit && (op_q == OP_INSERT) && has_room;
		do_full = !hit && (op_q == OP_INSERT) && !has_room;
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem[bucket];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + BW'(1);
			end
			if (state_q == ST_UPDATE && upd_go) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			key_q <= key;
			op_q  <= opcode;
		end
		if (rd_en) begin
			bucket_q <= bucket;
		end
		if (state_q == ST_UPDATE && upd_go) begin
			found_q    <= hit;
			inserted_q <= do_ins;
			full_q     <= do_full;
		end
	end

	assign out_valid   = out_valid_q;
	assign found       = found_q;
	assign inserted    = inserted_q;
	assign bucket_full = full_q;

endmodule
